>>> rtl/core/ekc_pkg.sv
// ----------------------------------------------------------------------------
// ekc_pkg
// Shared types and constants for the error keyword classifier: keyword text
// and length tables, class codes and the per-message state record.
// ----------------------------------------------------------------------------
package ekc_pkg;

	localparam int KW_COUNT = 16;
	localparam int KW_BYTES = 16;

	localparam logic [3:0] POS_SAT     = 4'd12;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [4:0] CLASS_NONE    = 5'd0;
	localparam logic [4:0] CLASS_UNKNOWN = 5'd17;

	typedef logic [KW_BYTES*8-1:0] kw_text_t;

	// keyword text right-justified: last character in the lowest byte
	localparam kw_text_t KW_TEXT [KW_COUNT] = '{
		kw_text_t'("ERR"),      kw_text_t'("BUSYGROUP"), kw_text_t'("NOGROUP"),
		kw_text_t'("WRONGTYPE"), kw_text_t'("NOAUTH"),   kw_text_t'("MOVED"),
		kw_text_t'("ASK"),      kw_text_t'("TRYAGAIN"),  kw_text_t'("CLUSTERDOWN"),
		kw_text_t'("READONLY"), kw_text_t'("NOSCRIPT"),  kw_text_t'("LOADING"),
		kw_text_t'("OOM"),      kw_text_t'("EXECABORT"), kw_text_t'("MASTERDOWN"),
		kw_text_t'("MISCONF")
	};

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd9, 4'd7, 4'd9, 4'd6, 4'd5, 4'd3, 4'd8,
		4'd11, 4'd8, 4'd8, 4'd7, 4'd3, 4'd9, 4'd10, 4'd7
	};

	typedef struct packed {
		logic                reply_is_error;
		logic                has_char;
		logic [7:0]          char_byte;
		logic                last_char;
	} item_t;

	typedef struct packed {
		logic [3:0]          pos;
		logic [KW_COUNT-1:0] alive;
		logic [KW_COUNT-1:0] matched;
		logic                is_err;
	} msg_state_t;

endpackage

>>> rtl/core/ekc_match.sv
// ----------------------------------------------------------------------------
// ekc_match
// Next-state and class logic: compares one character against all sixteen
// keywords in parallel and derives the class code for a closing item.
// ----------------------------------------------------------------------------
module ekc_match (
	input  ekc_pkg::msg_state_t state_cur,
	input  ekc_pkg::item_t      item,
	output ekc_pkg::msg_state_t state_nxt,
	output logic [4:0]          error_class
);

	logic [ekc_pkg::KW_COUNT-1:0] done;

	always_comb begin
		logic [3:0] idx;
		logic [7:0] kw_char;
		idx     = '0;
		kw_char = '0;
		state_nxt = state_cur;
		// error flag is resampled until the first character is taken
		if (state_cur.pos == 4'd0) begin
			state_nxt.is_err = item.reply_is_error;
		end
		if (item.has_char) begin
			for (int k = 0; k < ekc_pkg::KW_COUNT; k++) begin
				idx     = ekc_pkg::KW_LEN[k] - 4'd1 - state_cur.pos;
				kw_char = ekc_pkg::KW_TEXT[k][{idx, 3'b000} +: 8];
				if (state_cur.alive[k]) begin
					if (state_cur.pos < ekc_pkg::KW_LEN[k]) begin
						if (kw_char != item.char_byte) begin
							state_nxt.alive[k] = 1'b0;
						end
					end else begin
						if (state_cur.pos == ekc_pkg::KW_LEN[k] &&
						    item.char_byte == ekc_pkg::CHAR_SPACE) begin
							state_nxt.matched[k] = 1'b1;
						end
						state_nxt.alive[k] = 1'b0;
					end
				end
			end
			if (state_cur.pos < ekc_pkg::POS_SAT) begin
				state_nxt.pos = state_cur.pos + 4'd1;
			end
		end
	end

	always_comb begin
		for (int k = 0; k < ekc_pkg::KW_COUNT; k++) begin
			done[k] = state_nxt.matched[k] |
			          (state_nxt.alive[k] & (state_nxt.pos == ekc_pkg::KW_LEN[k]));
		end
		error_class = ekc_pkg::CLASS_UNKNOWN;
		// lowest code wins
		for (int k = ekc_pkg::KW_COUNT - 1; k >= 0; k--) begin
			if (done[k]) begin
				error_class = 5'(k + 1);
			end
		end
		if (!state_nxt.is_err) begin
			error_class = ekc_pkg::CLASS_NONE;
		end
	end

endmodule

>>> rtl/core/error_keyword_classifier_unit.sv
// ----------------------------------------------------------------------------
// error_keyword_classifier_unit
// Classifies a server error reply by its leading keyword, one character per
// word, giving one class code on the last word of each message.
//
//  channel  | dir | tdata             | tuser                         | tlast
//  ---------+-----+-------------------+-------------------------------+----------
//  s_axis   | in  | [7:0] char_byte   | [0] reply_is_error [1] has_char | last_char
//  m_axis   | out | [4:0] error_class | -                             | -
//
// One word per cycle while the input is not stalled: an input register, one
// pass of keyword compare logic, and a result register. A word waits in the
// input register until it advances into the message state; a closing word's
// class code is registered at that same edge. Only a closing word waits on a
// full result register, so the input stalls only while m_tready holds off.
// arst_n clears the message state, the input stage and the output.
// ----------------------------------------------------------------------------
module error_keyword_classifier_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_byte
	input  logic [1:0] s_tuser,   // [0] reply_is_error, [1] has_char
	input  logic       s_tlast,   // last_char
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [4:0] error_class, [7:5] zero
);

	ekc_pkg::item_t      item_s1;
	logic                valid_s1;
	logic                adv_s1;
	ekc_pkg::msg_state_t state_q;
	ekc_pkg::msg_state_t state_nxt;
	logic [4:0]          class_nxt;
	logic [4:0]          class_q;
	logic                out_valid_q;

	// a non-closing word never needs the result register
	assign adv_s1   = valid_s1 && (!item_s1.last_char || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.reply_is_error <= s_tuser[0];
			item_s1.has_char       <= s_tuser[1];
			item_s1.char_byte      <= s_tdata;
			item_s1.last_char      <= s_tlast;
		end
	end

	ekc_match u_match (
		.state_cur   (state_q),
		.item        (item_s1),
		.state_nxt   (state_nxt),
		.error_class (class_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.pos     <= 4'd0;
			state_q.alive   <= '1;
			state_q.matched <= '0;
			state_q.is_err  <= 1'b0;
		end else if (adv_s1) begin
			if (item_s1.last_char) begin
				state_q.pos     <= 4'd0;
				state_q.alive   <= '1;
				state_q.matched <= '0;
				state_q.is_err  <= 1'b0;
			end else begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && item_s1.last_char) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.last_char) begin
			class_q <= class_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, class_q};

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for error_keyword_classifier_unit. A short table of
// hand-built messages runs first, then random messages, mostly keyword based,
// with noise and broken ones. Both stream sides idle at random. The table
// carries its own class codes, a local keyword matcher predicts those of the
// random messages, and the bench compares every output word in order.
// ----------------------------------------------------------------------------
module testbench;

	localparam int RANDOM_WORDS = 2000;
	localparam int HOLD_AT      = 600;
	localparam int HOLD_CYCLES  = 150;
	localparam int QUIET_FROM   = 1200;
	localparam int QUIET_TO     = 1500;
	localparam int LIMIT_CYCLES = 400000;

	typedef enum logic [4:0] {
		EC_NONE, EC_ERR, EC_BUSYGROUP, EC_NOGROUP, EC_WRONGTYPE, EC_NOAUTH,
		EC_MOVED, EC_ASK, EC_TRYAGAIN, EC_CLUSTERDOWN, EC_READONLY, EC_NOSCRIPT,
		EC_LOADING, EC_OOM, EC_EXECABORT, EC_MASTERDOWN, EC_MISCONF, EC_UNKNOWN
	} class_e;

	typedef enum {
		MSG_EXACT, MSG_SPACED, MSG_JOINED, MSG_SHORT, MSG_BROKEN, MSG_NOISE, MSG_EMPTY
	} msg_kind_e;

	typedef struct packed {
		ekc_pkg::item_t word;
		logic           typed;
		class_e         code;
	} script_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;   // [7:0] char_byte
	logic [1:0] s_tuser = 2'b00;   // [0] reply_is_error, [1] has_char
	logic       s_tlast = 1'b0;    // last_char
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [4:0] error_class, [7:5] zero

	error_keyword_classifier_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	string kw_word [16] = '{
		"ERR", "BUSYGROUP", "NOGROUP", "WRONGTYPE", "NOAUTH", "MOVED", "ASK",
		"TRYAGAIN", "CLUSTERDOWN", "READONLY", "NOSCRIPT", "LOADING", "OOM",
		"EXECABORT", "MASTERDOWN", "MISCONF"
	};

	// fields per word: reply_is_error, has_char, char_byte, last_char
	script_row_t script [24] = '{
		'{'{1'b0, 1'b0, 8'h00, 1'b1}, 1'b1, EC_NONE},     // empty, not an error
		'{'{1'b1, 1'b0, 8'hFF, 1'b1}, 1'b1, EC_UNKNOWN},  // empty error reply
		'{'{1'b1, 1'b1, "E",   1'b0}, 1'b0, EC_NONE},
		'{'{1'b0, 1'b1, "R",   1'b0}, 1'b0, EC_NONE},
		'{'{1'b0, 1'b1, "R",   1'b1}, 1'b1, EC_ERR},
		'{'{1'b1, 1'b1, "O",   1'b0}, 1'b0, EC_NONE},
		'{'{1'b1, 1'b1, "O",   1'b0}, 1'b0, EC_NONE},
		'{'{1'b1, 1'b1, "M",   1'b0}, 1'b0, EC_NONE},
		'{'{1'b1, 1'b1, " ",   1'b1}, 1'b1, EC_OOM},
		// blank at the start samples the error flag, first char samples it again
		'{'{1'b1, 1'b0, 8'hA5, 1'b0}, 1'b0, EC_NONE},
		'{'{1'b0, 1'b1, "A",   1'b0}, 1'b0, EC_NONE},
		'{'{1'b1, 1'b1, "S",   1'b0}, 1'b0, EC_NONE},
		'{'{1'b1, 1'b0, 8'h5A, 1'b0}, 1'b0, EC_NONE},
		'{'{1'b1, 1'b1, "K",   1'b1}, 1'b1, EC_NONE},
		'{'{1'b1, 1'b1, 8'hFF, 1'b0}, 1'b0, EC_NONE},
		'{'{1'b0, 1'b1, 8'h00, 1'b1}, 1'b1, EC_UNKNOWN},
		'{'{1'b1, 1'b1, "E",   1'b0}, 1'b0, EC_NONE},
		'{'{1'b1, 1'b1, "R",   1'b0}, 1'b0, EC_NONE},
		'{'{1'b1, 1'b1, "R",   1'b0}, 1'b0, EC_NONE},
		'{'{1'b1, 1'b1, "X",   1'b1}, 1'b1, EC_UNKNOWN},
		// closing word carries no char
		'{'{1'b1, 1'b1, "E",   1'b0}, 1'b0, EC_NONE},
		'{'{1'b1, 1'b1, "R",   1'b0}, 1'b0, EC_NONE},
		'{'{1'b1, 1'b1, "R",   1'b0}, 1'b0, EC_NONE},
		'{'{1'b0, 1'b0, 8'h00, 1'b1}, 1'b1, EC_ERR}
	};

	// matcher state
	logic [3:0]  msg_pos = '0;
	logic [15:0] live_kw = '1;
	logic [15:0] done_kw = '0;
	logic        msg_err = 1'b0;

	class_e class_queue [$];
	class_e due_class;
	int     words_sent = 0;
	int     messages = 0;
	int     codes_checked = 0;
	int     mismatches = 0;
	int     cycle_count = 0;
	int     hold_left = 0;
	logic   hold_req = 1'b0;
	logic   hold_done = 1'b0;
	logic   quiet = 1'b0;

	// returns 1 when the word closes a message; code is then its class
	function automatic bit classify_word(ekc_pkg::item_t w, output class_e code);
		int k;
		int len;
		code = EC_NONE;
		if (msg_pos == 0)
			msg_err = w.reply_is_error;
		if (w.has_char) begin
			for (k = 0; k < 16; k++) begin
				len = kw_word[k].len();
				if (live_kw[k]) begin
					if (msg_pos < len) begin
						if (kw_word[k][msg_pos] != w.char_byte)
							live_kw[k] = 1'b0;
					end else begin
						if (msg_pos == len && w.char_byte == ekc_pkg::CHAR_SPACE)
							done_kw[k] = 1'b1;
						live_kw[k] = 1'b0;
					end
				end
			end
			if (msg_pos < ekc_pkg::POS_SAT)
				msg_pos++;
		end
		if (!w.last_char)
			return 1'b0;
		if (msg_err) begin
			code = EC_UNKNOWN;
			// walk down so the lowest keyword code wins
			for (k = 15; k >= 0; k--) begin
				if (done_kw[k] || (live_kw[k] && msg_pos == kw_word[k].len()))
					code = class_e'(k + 1);
			end
		end
		msg_pos = '0;
		live_kw = '1;
		done_kw = '0;
		msg_err = 1'b0;
		return 1'b1;
	endfunction

	task automatic send_word(ekc_pkg::item_t w, bit typed, class_e fixed);
		class_e code;
		if (!quiet && $urandom_range(99) < 22) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w.char_byte;
		s_tuser  <= {w.has_char, w.reply_is_error};
		s_tlast  <= w.last_char;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		if (classify_word(w, code))
			class_queue.push_back(typed ? fixed : code);
	endtask

	task automatic build_message(output ekc_pkg::item_t words[$]);
		msg_kind_e      kind;
		logic [7:0]     text [$];
		int             r;
		int             k;
		int             i;
		bit             err;
		ekc_pkg::item_t w;
		words = {};
		r = $urandom_range(99);
		kind = r < 20 ? MSG_EXACT : r < 45 ? MSG_SPACED : r < 55 ? MSG_JOINED :
			r < 65 ? MSG_SHORT : r < 75 ? MSG_BROKEN : r < 92 ? MSG_NOISE : MSG_EMPTY;
		k = $urandom_range(15);
		err = ($urandom_range(9) != 0);
		for (i = 0; i < kw_word[k].len(); i++)
			text.push_back(kw_word[k][i]);
		case (kind)
			MSG_SPACED: begin
				text.push_back(ekc_pkg::CHAR_SPACE);
				repeat ($urandom_range(6)) text.push_back(8'($urandom_range(255)));
			end
			MSG_JOINED: begin
				repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(33, 126)));
			end
			MSG_SHORT: begin
				repeat ($urandom_range(1, text.size() - 1)) void'(text.pop_back());
			end
			MSG_BROKEN: begin
				text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
			end
			MSG_NOISE: begin
				text = {};
				repeat ($urandom_range(1, 14)) text.push_back(8'($urandom_range(255)));
			end
			MSG_EMPTY: begin
				text = {};
			end
			default: ;
		endcase
		if (text.size() == 0) begin
			words.push_back('{err, 1'b0, 8'($urandom_range(255)), 1'b1});
			return;
		end
		if ($urandom_range(9) == 0)
			words.push_back('{1'($urandom), 1'b0, 8'($urandom_range(255)), 1'b0});
		foreach (text[j]) begin
			if (j > 0 && $urandom_range(19) == 0)
				words.push_back('{1'($urandom), 1'b0, 8'($urandom_range(255)), 1'b0});
			w.reply_is_error = (j == 0) ? err : 1'($urandom);
			w.has_char = 1'b1;
			w.char_byte = text[j];
			w.last_char = (j == text.size() - 1);
			words.push_back(w);
		end
		// sometimes the closing word is a blank one
		if ($urandom_range(19) == 0) begin
			words[$].last_char = 1'b0;
			words.push_back('{1'($urandom), 1'b0, 8'($urandom_range(255)), 1'b1});
		end
	endtask

	// output side: random stalls, one long hold-off, ordered compare
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (class_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("class word %0d with none expected", m_tdata);
			end else begin
				due_class = class_queue.pop_front();
				codes_checked++;
				if (m_tdata !== {3'b000, due_class}) begin
					mismatches++;
					if (mismatches <= 10)
						$display("class mismatch: expected %0d, got %0d", due_class, m_tdata);
				end
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(99) >= 18);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		ekc_pkg::item_t msg [$];
		int             rnd;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (script[i])
			send_word(script[i].word, script[i].typed, script[i].code);
		rnd = 0;
		while (rnd < RANDOM_WORDS) begin
			build_message(msg);
			foreach (msg[i])
				send_word(msg[i], 1'b0, EC_NONE);
			messages++;
			rnd = words_sent - $size(script);
			if (rnd >= HOLD_AT)
				hold_req <= 1'b1;
			quiet <= (rnd >= QUIET_FROM && rnd < QUIET_TO);
		end
		s_tvalid <= 1'b0;
		while (class_queue.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Ran %0d words (%0d random messages), checked %0d class codes,",
			words_sent, messages, codes_checked);
		$display("with random stalls on both sides and one long output hold-off.");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d bad class words", mismatches);
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
